// ----- sv/page_run_allocator_defines.svh -----
// Assertion macros of the page run allocator checker.
`ifndef PAGE_RUN_ALLOCATOR_DEFINES_SVH
`define PAGE_RUN_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define PRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define PRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pra_pkg.sv -----
// Types and constants of the page run allocator.
package pra_pkg;

  localparam int ACTION_W = 2;
  localparam int PAGE_W   = 10;
  localparam int COUNT_W  = 11;
  localparam int FRAME_W  = 20;
  localparam int STATUS_W = 2;
  localparam int DONE_W   = 11;
  localparam int FLAG_W   = 12;
  localparam int ENTRY_W  = FRAME_W + FLAG_W;

  // entry flag bits
  localparam int USED_POS = 9;
  localparam int CONT_POS = 10;

  // present and writable, not used, head of block
  localparam logic [FLAG_W-1:0] RESET_FLAGS = 12'h003;

  localparam logic [DONE_W-1:0] DONE_MAX = '1;

  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MAP   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_USED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHK_RD,
    ST_CHK_EX,
    ST_SET_RD,
    ST_SET_EX,
    ST_FREE_RD,
    ST_FREE_EX,
    ST_MAP_RD,
    ST_MAP_EX,
    ST_POST
  } pra_state_t;

endpackage

// ----- sv/page_run_allocator.sv -----
// Page run allocator: page table in a single-port RAM, walked by a sequencer.
//
//   channel | signals                                  | dir | beat
//   --------+------------------------------------------+-----+--------------------------
//   in      | in_valid in_ready action page count frame| in  | one request per beat
//   out     | out_valid out_ready status pages_done    | out | one result per request
//
// Each page entry is read, then checked or written, through the one RAM port and
// one shared pos+1 / end compare. Allocate runs a check pass, then a set pass
// (stopping early on a used page); free releases the block from its start page
// while chained, up to the table end; map reads one entry and writes its frame; a
// range error or an unknown action goes straight to the result. After rst the
// table is rewritten to its reset image, in_ready low meanwhile.
// A result waits in the output register; a further request may be taken then,
// and its result waits in ST_POST until the output register frees up.
module page_run_allocator #(
  parameter int NUM_PAGES = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pra_pkg::ACTION_W-1:0]   action,
  input  logic [pra_pkg::PAGE_W-1:0]     page,
  input  logic [pra_pkg::COUNT_W-1:0]    count,
  input  logic [pra_pkg::FRAME_W-1:0]    frame,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pra_pkg::STATUS_W-1:0]   status,
  output logic [pra_pkg::DONE_W-1:0]     pages_done
);
  import pra_pkg::*;

  localparam int IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  // position width: holds page+count (up to 3070) and NUM_PAGES itself
  localparam int PW = (IDX_W + 1 > 12) ? IDX_W + 1 : 12;
  localparam logic [PW-1:0] PAGES_P = PW'(NUM_PAGES);

  pra_state_t state, state_next;

  logic [PW-1:0]       pos, pos_next;       // current page of the walk
  logic [PW-1:0]       lim, lim_next;       // exclusive end of the walk
  logic [PW-1:0]       start, start_next;   // first page of the request
  logic [DONE_W-1:0]   size, size_next;     // pages walked by free
  logic [COUNT_W-1:0]  req_count, req_count_next;
  logic [FRAME_W-1:0]  req_frame, req_frame_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [DONE_W-1:0]   res_done, res_done_next;

  // page table
  logic [ENTRY_W-1:0] mem [NUM_PAGES];
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic               wr_en;
  logic [IDX_W-1:0]   addr;

  // shared step unit
  logic [PW-1:0] pos_inc;
  logic          at_end;

  logic [PW-1:0]     page_ext;
  logic [PW-1:0]     run_end;
  logic              run_past;
  logic              page_past;
  logic              walk;
  logic [DONE_W-1:0] size_inc;
  logic              out_free;

  assign addr     = pos[IDX_W-1:0];
  assign pos_inc  = pos + PW'(1);
  assign at_end   = (pos_inc == lim);

  assign page_ext  = PW'(page);
  assign run_end   = page_ext + PW'(count);
  assign run_past  = (run_end > PAGES_P);
  assign page_past = (page_ext >= PAGES_P);

  // start page always counts, later pages only while chained
  assign walk     = (pos == start) || rd_data[CONT_POS];
  assign size_inc = (size == DONE_MAX) ? size : size + DONE_W'(1);
  assign out_free = !out_valid || out_ready;

  assign in_ready = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (at_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (action)
            ACT_ALLOC: begin
              if (run_past || (count == '0)) state_next = ST_POST;
              else state_next = ST_CHK_RD;
            end
            ACT_FREE: begin
              state_next = page_past ? ST_POST : ST_FREE_RD;
            end
            ACT_MAP: begin
              state_next = page_past ? ST_POST : ST_MAP_RD;
            end
            default: state_next = ST_POST;
          endcase
        end
      end
      ST_CHK_RD: state_next = ST_CHK_EX;
      ST_CHK_EX: begin
        if (rd_data[USED_POS]) state_next = ST_POST;
        else if (at_end) state_next = ST_SET_RD;
        else state_next = ST_CHK_RD;
      end
      ST_SET_RD: state_next = ST_SET_EX;
      ST_SET_EX: begin
        state_next = at_end ? ST_POST : ST_SET_RD;
      end
      ST_FREE_RD: state_next = ST_FREE_EX;
      ST_FREE_EX: begin
        if (!walk || at_end) state_next = ST_POST;
        else state_next = ST_FREE_RD;
      end
      ST_MAP_RD: state_next = ST_MAP_EX;
      ST_MAP_EX: state_next = ST_POST;
      ST_POST: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    pos_next        = pos;
    lim_next        = lim;
    start_next      = start;
    size_next       = size;
    req_count_next  = req_count;
    req_frame_next  = req_frame;
    res_status_next = res_status;
    res_done_next   = res_done;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    wr_data         = rd_data;
    case (state)
      ST_CLEAR: begin
        // identity frame, reset flags
        wr_en    = 1'b1;
        wr_data  = {FRAME_W'(addr), RESET_FLAGS};
        pos_next = pos_inc;
      end
      ST_IDLE: begin
        if (in_valid) begin
          pos_next        = page_ext;
          start_next      = page_ext;
          size_next       = '0;
          req_count_next  = count;
          req_frame_next  = frame;
          res_status_next = STATUS_OK;
          res_done_next   = '0;
          lim_next        = PAGES_P;
          case (action)
            ACT_ALLOC: begin
              lim_next = run_end;
              if (run_past) res_status_next = STATUS_RANGE;
            end
            ACT_FREE, ACT_MAP: begin
              if (page_past) res_status_next = STATUS_RANGE;
            end
            default: res_status_next = STATUS_OK;
          endcase
        end
      end
      ST_CHK_RD, ST_SET_RD, ST_FREE_RD, ST_MAP_RD: begin
        rd_en = 1'b1;
      end
      ST_CHK_EX: begin
        if (rd_data[USED_POS]) res_status_next = STATUS_USED;
        else pos_next = at_end ? start : pos_inc;
      end
      ST_SET_EX: begin
        wr_en             = 1'b1;
        wr_data[USED_POS] = 1'b1;
        wr_data[CONT_POS] = (pos != start);
        pos_next          = pos_inc;
        res_done_next     = DONE_W'(req_count);
      end
      ST_FREE_EX: begin
        if (walk) begin
          wr_en             = 1'b1;
          wr_data[USED_POS] = 1'b0;
          size_next         = size_inc;
          pos_next          = pos_inc;
          res_done_next     = size_inc;
        end else begin
          res_done_next = size;
        end
      end
      ST_MAP_EX: begin
        wr_en   = 1'b1;
        wr_data = {req_frame, rd_data[FLAG_W-1:0]};
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      pos   <= '0;
      lim   <= PAGES_P;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      lim   <= lim_next;
    end
  end

  always_ff @(posedge clk) begin
    start      <= start_next;
    size       <= size_next;
    req_count  <= req_count_next;
    req_frame  <= req_frame_next;
    res_status <= res_status_next;
    res_done   <= res_done_next;
  end

  // table RAM: one address, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_POST) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_POST) && out_free) begin
      status     <= res_status;
      pages_done <= res_done;
    end
  end

endmodule

// ----- sv/pra_checker.sv -----
// Port-level checks of the page run allocator, bound to the top level.
`include "page_run_allocator_defines.svh"

module pra_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [pra_pkg::ACTION_W-1:0] action,
  input logic [pra_pkg::PAGE_W-1:0]   page,
  input logic [pra_pkg::COUNT_W-1:0]  count,
  input logic [pra_pkg::FRAME_W-1:0]  frame,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pra_pkg::STATUS_W-1:0] status,
  input logic [pra_pkg::DONE_W-1:0]   pages_done
);
  import pra_pkg::*;

  // stalled result beat holds
  `PRA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(pages_done), "result beat changed while stalled")

  // failed requests report no pages
  `PRA_ASSERT_NOW(a_fail_zero, out_valid && (status != STATUS_OK), pages_done == '0, "failed request reports pages")

  // one request in flight: busy right after a request beat
  `PRA_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "ready right after request beat")

endmodule

bind page_run_allocator pra_checker u_pra_checker (.*);
